// ===== sv/fpim_pkg.sv =====
// ----------------------------------------------------------------------------
// fpim_pkg: shared types and constants of the fall monitor
// Event and phase codes, register indexes, reset values and the records that
// pass between the front end, the event queue and the back end.
// ----------------------------------------------------------------------------
package fpim_pkg;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_FREEFALL = 2'd1,
    MODE_SAMPLE   = 2'd2,
    MODE_BUTTON   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_FALLING = 2'd1,
    PH_SHOWING = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    FE_TAKE,
    FE_SQUARE,
    FE_PUSH
  } front_state_e;

  typedef enum logic {
    BK_RUN,
    BK_ROOT
  } back_state_e;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_HIGH    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SETTLE_SAMPLES = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BLINK_TICKS    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SHOW_TICKS     = 3'd4;

  // Register reset values
  localparam logic [31:0] WindowLowRst  = 32'd9000;
  localparam logic [31:0] WindowHighRst = 32'd10000;
  localparam logic [3:0]  SettleRst     = 4'd5;
  localparam logic [15:0] BlinkRst      = 16'd500;
  localparam logic [15:0] ShowRst       = 16'd10000;

  // Datapath widths
  localparam int MagW      = 34;
  localparam int RootW     = 17;
  localparam int RootIters = 17;
  localparam logic [MagW-1:0] RootStartBit = MagW'(1) << (2 * (RootIters - 1));

  // Event queue
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [31:0] window_low;
    logic [31:0] window_high;
    logic [3:0]  settle_samples;
    logic [15:0] blink_ticks;
    logic [15:0] show_ticks;
  } cfg_t;

  typedef struct packed {
    mode_e           mode;
    logic [MagW-1:0] mag;
    logic            at_rest;
  } evt_t;

  typedef struct packed {
    phase_e      phase;
    logic        led_on;
    logic        fall_done;
    logic [15:0] peak_magnitude;
    logic [15:0] fall_ticks;
  } res_t;

endpackage

// ===== sv/fpim_if.sv =====
// ----------------------------------------------------------------------------
// fpim channel interfaces
// Event request channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface fpim_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic signed [15:0] acc_z;

  modport source (output valid, mode, acc_x, acc_y, acc_z, input ready);
  modport sink   (input valid, mode, acc_x, acc_y, acc_z, output ready);
endinterface

interface fpim_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  phase;
  logic        led_on;
  logic        fall_done;
  logic [15:0] peak_magnitude;
  logic [15:0] fall_ticks;

  modport source (output valid, phase, led_on, fall_done, peak_magnitude, fall_ticks,
                  input ready);
  modport sink   (input valid, phase, led_on, fall_done, peak_magnitude, fall_ticks,
                  output ready);
endinterface

interface fpim_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fpim_pkg::CfgIdxW-1:0]  index;
  logic [31:0]                   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/fpim_front.sv =====
// ----------------------------------------------------------------------------
// fpim_front: event intake and classification
// Takes one event request, forms the squared magnitude of a sample with one
// shared multiplier, axis by axis, flags the at-rest window and pushes
// the classified event into the queue.
// ----------------------------------------------------------------------------
module fpim_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  fpim_in_if.sink          in_ch,
  input  fpim_pkg::cfg_t   cfg_i,
  input  logic             full_i,
  output logic             push_o,
  output fpim_pkg::evt_t   evt_o
);
  import fpim_pkg::*;

  front_state_e       state_q, state_d;
  logic [1:0]         idx_q, idx_d;
  logic [MagW-1:0]    acc_q, acc_d;
  mode_e              mode_q;
  logic signed [15:0] ax_q, ay_q, az_q;
  logic signed [15:0] op;
  logic signed [31:0] sq;
  logic               take;

  always_comb begin
    case (idx_q)
      2'd0:    op = ax_q;
      2'd1:    op = ay_q;
      default: op = az_q;
    endcase
  end

  assign sq = op * op;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    in_ch.ready = 1'b0;
    push_o      = 1'b0;
    take        = 1'b0;
    unique case (state_q)
      FE_TAKE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          take  = 1'b1;
          acc_d = '0;
          idx_d = 2'd0;
          state_d = (mode_e'(in_ch.mode) == MODE_SAMPLE) ? FE_SQUARE : FE_PUSH;
        end
      end
      FE_SQUARE: begin
        // accumulate one axis per cycle
        acc_d = acc_q + {2'b00, sq[31:0]};
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd2) begin
          state_d = FE_PUSH;
        end
      end
      FE_PUSH: begin
        push_o = !full_i;
        if (!full_i) begin
          state_d = FE_TAKE;
        end
      end
      default: state_d = FE_TAKE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_TAKE;
      idx_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (take) begin
      mode_q <= mode_e'(in_ch.mode);
      ax_q   <= in_ch.acc_x;
      ay_q   <= in_ch.acc_y;
      az_q   <= in_ch.acc_z;
    end
  end

  assign evt_o.mode    = mode_q;
  assign evt_o.mag     = acc_q;
  assign evt_o.at_rest = (acc_q > {2'b00, cfg_i.window_low}) &&
                         (acc_q < {2'b00, cfg_i.window_high});

endmodule

// ===== sv/fpim_queue.sv =====
// ----------------------------------------------------------------------------
// fpim_queue: classified event queue
// Short first-in first-out buffer that decouples intake from execution.
// ----------------------------------------------------------------------------
module fpim_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fpim_pkg::evt_t  evt_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output fpim_pkg::evt_t  evt_o
);
  import fpim_pkg::*;

  evt_t             entries_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign evt_o   = entries_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_q] <= evt_i;
    end
  end

endmodule

// ===== sv/fpim_isqrt.sv =====
// ----------------------------------------------------------------------------
// fpim_isqrt: iterative integer square root
// Bit-pair restoring square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fpim_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fpim_pkg::MagW-1:0]   value_i,
  output logic                        done_o,
  output logic [fpim_pkg::RootW-1:0]  root_o
);
  import fpim_pkg::*;

  logic            busy_q, busy_d, done_q, done_d;
  logic [MagW-1:0] rem_q, rem_d, root_q, root_d, bit_q, bit_d;
  logic [MagW:0]   trial;

  assign trial = {1'b0, root_q} + {1'b0, bit_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      rem_d  = value_i;
      root_d = '0;
      bit_d  = RootStartBit;
    end else if (busy_q) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d  = rem_q - trial[MagW-1:0];
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      // last pair consumed
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = root_q[RootW-1:0];

endmodule

// ===== sv/fpim_back.sv =====
// ----------------------------------------------------------------------------
// fpim_back: phase sequencer and result register
// Applies queued events to the phase state, starts the square root when a
// fall settles and holds each result until the sink takes it.
// ----------------------------------------------------------------------------
module fpim_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fpim_pkg::cfg_t              cfg_i,
  input  logic                        evt_valid_i,
  input  fpim_pkg::evt_t              evt_i,
  output logic                        pop_o,
  output logic                        root_start_o,
  output logic [fpim_pkg::MagW-1:0]   root_value_o,
  input  logic                        root_done_i,
  input  logic [fpim_pkg::RootW-1:0]  root_i,
  fpim_out_if.source                  out_ch
);
  import fpim_pkg::*;

  back_state_e     st_q, st_d;
  phase_e          phase_q, phase_d;
  logic [MagW-1:0] peak_q, peak_d;
  logic [3:0]      rest_q, rest_d;
  logic [15:0]     blink_q, blink_d, show_q, show_d, dur_q, dur_d, root_q, root_d;
  logic            led_q, led_d;
  logic            out_vld_q, out_vld_d;
  res_t            out_q, out_d;
  logic            out_free, load_out, go_idle, fall_end;
  logic [15:0]     bl, sl;
  logic [3:0]      rc;

  assign out_free = !out_vld_q || out_ch.ready;

  always_comb begin
    st_d         = st_q;
    phase_d      = phase_q;
    peak_d       = peak_q;
    rest_d       = rest_q;
    blink_d      = blink_q;
    show_d       = show_q;
    dur_d        = dur_q;
    root_d       = root_q;
    led_d        = led_q;
    out_d        = out_q;
    load_out     = 1'b0;
    pop_o        = 1'b0;
    root_start_o = 1'b0;
    go_idle      = 1'b0;
    fall_end     = 1'b0;
    bl           = blink_q;
    sl           = show_q;
    rc           = rest_q;

    unique case (st_q)
      BK_RUN: begin
        if (evt_valid_i && out_free) begin
          pop_o = 1'b1;
          unique case (evt_i.mode)
            MODE_TICK: begin
              if (phase_q != PH_IDLE) begin
                if (bl != 16'd0) bl = bl - 16'd1;
                if (bl == 16'd0) begin
                  led_d = !led_q;
                  bl    = cfg_i.blink_ticks;
                end
                blink_d = bl;
                if (phase_q == PH_FALLING) begin
                  if (dur_q != 16'hFFFF) dur_d = dur_q + 16'd1;
                end else begin
                  if (sl != 16'd0) sl = sl - 16'd1;
                  show_d = sl;
                  if (sl == 16'd0) go_idle = 1'b1;
                end
              end
            end
            MODE_FREEFALL: begin
              if (phase_q == PH_IDLE) begin
                phase_d = PH_FALLING;
                led_d   = 1'b1;
                peak_d  = '0;
                rest_d  = 4'd0;
                dur_d   = 16'd0;
                blink_d = cfg_i.blink_ticks;
              end
            end
            MODE_SAMPLE: begin
              if (phase_q == PH_FALLING) begin
                if (evt_i.mag >= peak_q) peak_d = evt_i.mag;
                if (evt_i.at_rest) begin
                  rc = (rest_q != 4'd15) ? rest_q + 4'd1 : rest_q;
                end else begin
                  rc = 4'd0;
                end
                rest_d = rc;
                if (rc >= cfg_i.settle_samples) begin
                  fall_end = 1'b1;
                  phase_d  = PH_SHOWING;
                  show_d   = cfg_i.show_ticks;
                end
              end
            end
            MODE_BUTTON: begin
              if (phase_q == PH_SHOWING) go_idle = 1'b1;
            end
            default: ;
          endcase

          if (go_idle) begin
            phase_d = PH_IDLE;
            peak_d  = '0;
            rest_d  = 4'd0;
            blink_d = cfg_i.blink_ticks;
            show_d  = cfg_i.show_ticks;
            led_d   = 1'b0;
            dur_d   = 16'd0;
            root_d  = 16'd0;
          end

          if (fall_end) begin
            // hold the result until the root is ready
            root_start_o = 1'b1;
            st_d         = BK_ROOT;
          end else begin
            load_out             = 1'b1;
            out_d.phase          = phase_d;
            out_d.led_on         = led_d;
            out_d.fall_done      = 1'b0;
            out_d.peak_magnitude = root_d;
            out_d.fall_ticks     = dur_d;
          end
        end
      end
      BK_ROOT: begin
        if (root_done_i && out_free) begin
          root_d               = root_i[15:0];
          load_out             = 1'b1;
          out_d.phase          = phase_q;
          out_d.led_on         = led_q;
          out_d.fall_done      = 1'b1;
          out_d.peak_magnitude = root_i[15:0];
          out_d.fall_ticks     = dur_q;
          st_d                 = BK_RUN;
        end
      end
      default: st_d = BK_RUN;
    endcase

    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  assign root_value_o = peak_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= BK_RUN;
      phase_q   <= PH_IDLE;
      peak_q    <= '0;
      rest_q    <= 4'd0;
      blink_q   <= BlinkRst;
      show_q    <= ShowRst;
      dur_q     <= 16'd0;
      root_q    <= 16'd0;
      led_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      phase_q   <= phase_d;
      peak_q    <= peak_d;
      rest_q    <= rest_d;
      blink_q   <= blink_d;
      show_q    <= show_d;
      dur_q     <= dur_d;
      root_q    <= root_d;
      led_q     <= led_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_ch.valid          = out_vld_q;
  assign out_ch.phase          = out_q.phase;
  assign out_ch.led_on         = out_q.led_on;
  assign out_ch.fall_done      = out_q.fall_done;
  assign out_ch.peak_magnitude = out_q.peak_magnitude;
  assign out_ch.fall_ticks     = out_q.fall_ticks;

endmodule

// ===== sv/freefall_peak_impact_monitor.sv =====
// ----------------------------------------------------------------------------
// freefall_peak_impact_monitor: three-phase fall and impact monitor
// Tracks idle, falling and showing phases from tick, freefall, sample and
// button event requests and reports one result per event.
// ----------------------------------------------------------------------------
// Every accepted event request yields exactly one result, in order. A sample
// is squared by the single shared 16x16 multiplier, which forms x*x, y*y and
// z*z one after another. The sample that settles a fall also waits for the
// one-bit-per-cycle square root of the 34-bit peak before its result appears.
// A two-entry event queue sits between intake and the phase sequencer, and a
// result register holds each result until it is taken, so new requests are
// still accepted while a result waits, until the queue and intake are full.
// Register writes are taken on any cycle, always ready; write them only while
// no event is in flight. Writes to blink_ticks and show_ticks apply at the
// next reload.
// ----------------------------------------------------------------------------
module freefall_peak_impact_monitor (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpim_in_if.sink    in_ch,
  fpim_cfg_if.sink   cfg_ch,
  fpim_out_if.source out_ch
);
  import fpim_pkg::*;

  cfg_t             cfg_q;
  evt_t             front_evt, queue_evt;
  logic             push, full, pop, queue_valid;
  logic             root_start, root_done;
  logic [MagW-1:0]  root_value;
  logic [RootW-1:0] root;

  // Register file: always ready, ignore indexes past the list
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_low     <= WindowLowRst;
      cfg_q.window_high    <= WindowHighRst;
      cfg_q.settle_samples <= SettleRst;
      cfg_q.blink_ticks    <= BlinkRst;
      cfg_q.show_ticks     <= ShowRst;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_WINDOW_LOW:     cfg_q.window_low     <= cfg_ch.data;
        REG_WINDOW_HIGH:    cfg_q.window_high    <= cfg_ch.data;
        REG_SETTLE_SAMPLES: cfg_q.settle_samples <= cfg_ch.data[3:0];
        REG_BLINK_TICKS:    cfg_q.blink_ticks    <= cfg_ch.data[15:0];
        REG_SHOW_TICKS:     cfg_q.show_ticks     <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // Intake: square and classify each request
  fpim_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .evt_o  (front_evt)
  );

  // Decouple intake from the sequencer
  fpim_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .evt_i   (front_evt),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .evt_o   (queue_evt)
  );

  // Peak root, run once per settled fall
  fpim_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (root_value),
    .done_o  (root_done),
    .root_o  (root)
  );

  // Phase sequencer and result register
  fpim_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .evt_valid_i  (queue_valid),
    .evt_i        (queue_evt),
    .pop_o        (pop),
    .root_start_o (root_start),
    .root_value_o (root_value),
    .root_done_i  (root_done),
    .root_i       (root),
    .out_ch       (out_ch)
  );

endmodule

// ===== sv/fpim_checker.sv =====
// ----------------------------------------------------------------------------
// fpim_checker: port-level checks of the fall monitor
// Relations between the result fields, plus result hold under stall.
// ----------------------------------------------------------------------------
module fpim_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  phase_i,
  input logic        led_on_i,
  input logic        fall_done_i,
  input logic [15:0] peak_magnitude_i,
  input logic [15:0] fall_ticks_i
);
  import fpim_pkg::*;

  // A fall ends only by entering showing
  a_done_showing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fall_done_i |-> phase_i == PH_SHOWING)
    else $error("fall_done outside showing");

  // Idle means led, peak and fall ticks are back at reset
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && phase_i == PH_IDLE |->
      !led_on_i && peak_magnitude_i == 16'd0 && fall_ticks_i == 16'd0)
    else $error("idle result not cleared");

  // No root is latched before the fall settles
  a_falling_noroot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && phase_i == PH_FALLING |-> peak_magnitude_i == 16'd0 && !fall_done_i)
    else $error("root shown while falling");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(phase_i) &&
      $stable(led_on_i) && $stable(fall_done_i) && $stable(peak_magnitude_i) &&
      $stable(fall_ticks_i))
    else $error("stalled result changed");

endmodule

bind freefall_peak_impact_monitor fpim_checker u_fpim_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_ch.valid),
  .out_ready_i      (out_ch.ready),
  .phase_i          (out_ch.phase),
  .led_on_i         (out_ch.led_on),
  .fall_done_i      (out_ch.fall_done),
  .peak_magnitude_i (out_ch.peak_magnitude),
  .fall_ticks_i     (out_ch.fall_ticks)
);
